>>> design/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: payload structs,
// opcodes, status codes and the per-cycle control word broadcast to cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH     = 32;
   localparam int WORD_BITS = 32;

   // opcodes
   localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_REAR   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [2:0] opcode;
      word_type   value_in;
   } req_payload_type;

   typedef struct packed {
      word_type   value_out;
      logic [1:0] status;
      logic       now_empty;
      logic       now_full;
   } rsp_payload_type;

   // qualified operation, broadcast to every cell
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
      logic clear;
   } cell_ctrl_type;

endpackage : cdq_pkg
`default_nettype wire

>>> design/cdq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the shifting deque. Holds a word and an occupied flag, and
// moves data to or from its neighbors on front pushes and front pops.
// ----------------------------------------------------------------------------
module cdq_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cdq_pkg::cell_ctrl_type ctrl,
   input  wire cdq_pkg::word_type  push_word,
   input  wire logic               left_valid,
   input  wire cdq_pkg::word_type  left_data,
   input  wire logic               right_valid,
   input  wire cdq_pkg::word_type  right_data,
   output logic                    valid,
   output cdq_pkg::word_type       data,
   output cdq_pkg::word_type       tail_data
);
   import cdq_pkg::*;

   logic     valid_ff, valid_in;
   word_type data_ff, data_in;

   // next slot contents
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.push_front) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (ctrl.push_rear) begin
         if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            data_in  = push_word;
         end
      end else if (ctrl.pop_front) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctrl.pop_rear) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid     = valid_ff;
   assign data      = data_ff;
   // rear word, masked so the top can or-reduce across cells
   assign tail_data = (valid_ff && !right_valid) ? data_ff : '0;

endmodule : cdq_cell
`default_nettype wire

>>> design/circular_deque_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of DEPTH words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation (opcode, value_in) per transfer; rsp_* returns
//   exactly one result per operation, in order: popped word, status, and the
//   empty and full flags after the operation.
//   Word order is kept front-aligned: cell 0 is the front, the last occupied
//   cell is the rear. Front push and front pop shift the whole row by one
//   cell together; rear push and rear pop touch one cell.
//   The response is registered: rsp_valid rises in the cycle after the
//   request transfer. One operation is accepted per cycle while the
//   receiver takes responses; the response register holds one entry.
//   A push on a full deque or a pop on an empty one leaves the contents as
//   they were and reports full or empty in status.
//   Reset empties the deque at once (occupied flags cleared); no sweep.
//   When the receiver stalls, the response register holds and req_ready
//   drops until the pending response transfers.
// ----------------------------------------------------------------------------
module circular_deque_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire cdq_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output cdq_pkg::rsp_payload_type      rsp_payload
);
   import cdq_pkg::*;

   logic            cell_valid [DEPTH];
   word_type        cell_data  [DEPTH];
   word_type        cell_tail  [DEPTH];
   cell_ctrl_type   ctrl;
   word_type        tail_word;
   logic            is_empty, is_full, accept;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   assign is_empty  = !cell_valid[0];
   assign is_full   = cell_valid[DEPTH-1];
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // qualified operation for the cells
   always_comb begin
      ctrl            = '0;
      ctrl.push_rear  = accept && (req_payload.opcode == OP_PUSH_REAR)  && !is_full;
      ctrl.push_front = accept && (req_payload.opcode == OP_PUSH_FRONT) && !is_full;
      ctrl.pop_rear   = accept && (req_payload.opcode == OP_POP_REAR)   && !is_empty;
      ctrl.pop_front  = accept && (req_payload.opcode == OP_POP_FRONT)  && !is_empty;
      ctrl.clear      = accept && (req_payload.opcode == OP_CLEAR);
   end

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     lv, rv;
      word_type ld, rd;
      if (i == 0) begin : g_first
         assign lv = 1'b1;
         assign ld = req_payload.value_in;
      end else begin : g_mid_l
         assign lv = cell_valid[i-1];
         assign ld = cell_data[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_mid_r
         assign rv = cell_valid[i+1];
         assign rd = cell_data[i+1];
      end
      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_word   (req_payload.value_in),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .tail_data   (cell_tail[i])
      );
   end

   // rear word: at most one cell, the rear one, passes its word; the rest drive zero
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   // response for the current operation
   always_comb begin
      rsp_in.value_out = '0;
      rsp_in.status    = ST_DONE;
      rsp_in.now_empty = is_empty;
      rsp_in.now_full  = is_full;
      case (req_payload.opcode)
         OP_PUSH_REAR, OP_PUSH_FRONT: begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.now_empty = 1'b0;
               rsp_in.now_full  = cell_valid[DEPTH-2];
            end
         end
         OP_POP_REAR: begin
            if (is_empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.value_out = tail_word;
               rsp_in.now_empty = !cell_valid[1];
               rsp_in.now_full  = 1'b0;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.value_out = cell_data[0];
               rsp_in.now_empty = !cell_valid[1];
               rsp_in.now_full  = 1'b0;
            end
         end
         OP_CLEAR: begin
            rsp_in.now_empty = 1'b1;
            rsp_in.now_full  = 1'b0;
         end
         default: begin
            rsp_in.status = ST_DONE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : circular_deque_top
`default_nettype wire

>>> sim/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches both channels of the circular deque. Every request transfer runs
// through a shadow deque that yields the response it must produce; every
// response transfer is compared field by field with the oldest of those.
// ----------------------------------------------------------------------------
module cdq_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire cdq_pkg::req_payload_type req_payload,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire cdq_pkg::rsp_payload_type rsp_payload,
   output int unsigned                   mismatch_count,
   output int unsigned                   outstanding
);

   import cdq_pkg::*;

   // shadow deque
   word_type        mirror_words [DEPTH];
   int unsigned     mirror_front;
   int unsigned     mirror_rear;
   logic            mirror_vacant;

   rsp_payload_type pending_results [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] cdq mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int unsigned slot_after(input int unsigned idx);
      return (idx + 1) % DEPTH;
   endfunction

   function automatic int unsigned slot_before(input int unsigned idx);
      return (idx + DEPTH - 1) % DEPTH;
   endfunction

   function automatic logic deque_is_full();
      return !mirror_vacant && (slot_after(mirror_rear) == mirror_front);
   endfunction

   // run one operation on the shadow deque and return its response
   function automatic rsp_payload_type apply_deque_op(input req_payload_type item);
      rsp_payload_type outcome;
      outcome        = '0;
      outcome.status = ST_DONE;
      case (item.opcode)
         OP_PUSH_REAR, OP_PUSH_FRONT: begin
            if (deque_is_full()) begin
               outcome.status = ST_FULL;
            end else if (mirror_vacant) begin
               // first word always lands in slot zero
               mirror_front    = 0;
               mirror_rear     = 0;
               mirror_words[0] = item.value_in;
               mirror_vacant   = 1'b0;
            end else if (item.opcode == OP_PUSH_REAR) begin
               mirror_rear               = slot_after(mirror_rear);
               mirror_words[mirror_rear] = item.value_in;
            end else begin
               mirror_front               = slot_before(mirror_front);
               mirror_words[mirror_front] = item.value_in;
            end
         end
         OP_POP_REAR, OP_POP_FRONT: begin
            if (mirror_vacant) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.value_out = (item.opcode == OP_POP_REAR) ?
                                   mirror_words[mirror_rear] : mirror_words[mirror_front];
               // last word out resets both pointers
               if (mirror_front == mirror_rear) begin
                  mirror_front  = 0;
                  mirror_rear   = 0;
                  mirror_vacant = 1'b1;
               end else if (item.opcode == OP_POP_REAR) begin
                  mirror_rear = slot_before(mirror_rear);
               end else begin
                  mirror_front = slot_after(mirror_front);
               end
            end
         end
         OP_CLEAR: begin
            mirror_front  = 0;
            mirror_rear   = 0;
            mirror_vacant = 1'b1;
         end
         default: begin
            // spare opcodes leave everything alone
         end
      endcase
      outcome.now_empty = mirror_vacant;
      outcome.now_full  = deque_is_full();
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         mirror_front  = 0;
         mirror_rear   = 0;
         mirror_vacant = 1'b1;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         // response transfer: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response transfer with no operation pending");
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.value_out !== want.value_out) begin
                  report_mismatch($sformatf("value_out got %0d want %0d",
                                            rsp_payload.value_out, want.value_out));
               end
               if (rsp_payload.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_payload.status, want.status));
               end
               if (rsp_payload.now_empty !== want.now_empty) begin
                  report_mismatch($sformatf("now_empty got %b want %b",
                                            rsp_payload.now_empty, want.now_empty));
               end
               if (rsp_payload.now_full !== want.now_full) begin
                  report_mismatch($sformatf("now_full got %b want %b",
                                            rsp_payload.now_full, want.now_full));
               end
            end
         end
         // request transfer: predict its response
         if (req_valid && req_ready) begin
            pending_results.push_back(apply_deque_op(req_payload));
         end
         outstanding <= pending_results.size();
      end
   end

endmodule : cdq_checker

>>> sim/circular_deque_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_top_tb
// Drives operations into the circular deque: a short directed sequence over
// the corner cases, then random bursts that fill, drain, mix and inject spare
// opcodes, with random gaps on the request side and random stalls on the
// response side. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module circular_deque_top_tb;

   import cdq_pkg::*;

   localparam int unsigned OP_TARGET      = 1300;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 20;

   // opcodes with no operation behind them
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   // burst flavors for the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;
   localparam int MODE_NOISE = 3;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   int unsigned     mismatch_count;
   int unsigned     outstanding;

   bit              req_calm = 1'b0;
   bit              rsp_calm = 1'b0;
   int unsigned     rsp_hold = 0;

   circular_deque_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   cdq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stall after every transfer
   always @(posedge clock) begin
      int unsigned hold_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         hold_draw = rsp_calm ? 0 : $urandom_range(0, 11);
         rsp_hold  <= (hold_draw == 0) ? 0 : hold_draw - 1;
         rsp_ready <= (hold_draw == 0);
      end else if (!rsp_ready) begin
         if (rsp_hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[%0t] no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic word_type random_word();
      case ($urandom_range(0, 11))
         0:       return {1'b1, {(WORD_BITS-1){1'b0}}};
         1:       return {1'b0, {(WORD_BITS-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // one request transfer, after a random gap unless the sender runs calm
   task automatic send_item(input logic [2:0] opcode, input word_type value);
      int unsigned     gap;
      req_payload_type item;
      gap            = req_calm ? 0 : $urandom_range(0, 11);
      item.opcode    = opcode;
      item.value_in  = value;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the request side until every response is back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned ops_sent;
      int unsigned burst_len;
      int unsigned push_pct;
      int unsigned roll;
      int          mode;
      logic [2:0]  opcode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty rejects, first push, last pop, both ends, spares, clear
      send_item(OP_POP_REAR, random_word());
      send_item(OP_POP_FRONT, random_word());
      send_item(OP_PUSH_REAR, {1'b0, {(WORD_BITS-1){1'b1}}});
      send_item(OP_POP_FRONT, random_word());
      send_item(OP_PUSH_FRONT, {1'b1, {(WORD_BITS-1){1'b0}}});
      send_item(OP_PUSH_REAR, '0);
      send_item(OP_PUSH_FRONT, '1);
      send_item(OP_PUSH_REAR, 32'h5555_5555);
      send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_item(OP_POP_REAR, random_word());
      send_item(OP_POP_FRONT, random_word());
      send_item(OP_SPARE_LO, random_word());
      send_item(OP_SPARE_MID, random_word());
      send_item(OP_SPARE_HI, '1);
      send_item(OP_CLEAR, random_word());
      send_item(OP_POP_FRONT, random_word());
      send_item(OP_PUSH_FRONT, 32'h0000_0001);
      send_item(OP_POP_REAR, random_word());
      send_item(OP_CLEAR, '1);
      pause_until_drained();

      // random bursts
      ops_sent = 0;
      while (ops_sent < OP_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: mode = MODE_FILL;
            3, 4, 5: mode = MODE_DRAIN;
            6, 7, 8: mode = MODE_MIXED;
            default: mode = MODE_NOISE;
         endcase
         push_pct  = (mode == MODE_FILL) ? 88 : (mode == MODE_DRAIN) ? 12 : 50;
         burst_len = (mode == MODE_NOISE) ? $urandom_range(4, 16) : $urandom_range(8, 60);
         req_calm  = ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) begin
            pause_until_drained();
         end
         repeat (burst_len) begin
            roll = $urandom_range(0, 99);
            if (mode == MODE_NOISE) begin
               opcode = 3'($urandom_range(0, 7));
            end else if (mode == MODE_MIXED && roll < 2) begin
               opcode = OP_CLEAR;
            end else if (roll < push_pct) begin
               opcode = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else begin
               opcode = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            end
            send_item(opcode, random_word());
            if (opcode <= OP_CLEAR) begin
               ops_sent++;
            end
         end
      end

      // let the last responses come back, then give the verdict
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : circular_deque_top_tb
